// ----- rtl/tsp_pkg.sv -----
// Shared types, constants and format decode helpers of the timestamp text parser.
package tsp_pkg;

  // Format modes held in the configuration register
  localparam logic [1:0] MODE_FULL = 2'd0;
  localparam logic [1:0] MODE_HMS  = 2'd1;
  localparam logic [1:0] MODE_HM   = 2'd2;

  // Character counts of the three formats
  localparam logic [4:0] LEN_FULL = 5'd19;
  localparam logic [4:0] LEN_HMS  = 5'd8;
  localparam logic [4:0] LEN_HM   = 5'd5;

  // Field selected by a character position
  localparam logic [2:0] FLD_SEP  = 3'd0;
  localparam logic [2:0] FLD_YEAR = 3'd1;
  localparam logic [2:0] FLD_MON  = 3'd2;
  localparam logic [2:0] FLD_DAY  = 3'd3;
  localparam logic [2:0] FLD_HOUR = 3'd4;
  localparam logic [2:0] FLD_MIN  = 3'd5;
  localparam logic [2:0] FLD_SEC  = 3'd6;

  // ASCII codes used by the checks
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Range limits
  localparam logic [6:0] MAX_HOUR = 7'd23;
  localparam logic [6:0] MAX_MIN  = 7'd59;
  localparam logic [6:0] MAX_SEC  = 7'd60;
  localparam logic [6:0] MAX_MON  = 7'd12;
  localparam logic [6:0] MAX_DAY  = 7'd31;

  // Output field widths
  localparam int unsigned DATE_W = 27;
  localparam int unsigned TIME_W = 18;

  // What one character position expects: a digit of a field, or a separator
  typedef struct packed {
    logic [2:0] fld;
    logic [7:0] sep;
  } slot_t;

  // Accumulated fields handed from the character stage to the result stage
  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  pos;
    logic        err;
    logic [13:0] year;
    logic [6:0]  mon;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  sec;
  } fin_t;

  // Length of the format selected by a mode; the unused mode takes nothing
  function automatic logic [4:0] fmt_len(input logic [1:0] mode);
    logic [4:0] len;
    unique case (mode)
      MODE_FULL: len = LEN_FULL;
      MODE_HMS:  len = LEN_HMS;
      MODE_HM:   len = LEN_HM;
      default:   len = 5'd0;
    endcase
    return len;
  endfunction

  // Position decode of the three templates
  function automatic slot_t slot_of(input logic [1:0] mode, input logic [4:0] pos);
    slot_t s;
    s.fld = FLD_SEP;
    s.sep = CH_COLON;
    if (mode == MODE_FULL) begin
      case (pos) inside
        [5'd0:5'd3]:   s.fld = FLD_YEAR;
        5'd4, 5'd7:    s.sep = CH_DASH;
        5'd5, 5'd6:    s.fld = FLD_MON;
        5'd8, 5'd9:    s.fld = FLD_DAY;
        5'd10:         s.sep = CH_SPACE;
        5'd11, 5'd12:  s.fld = FLD_HOUR;
        5'd14, 5'd15:  s.fld = FLD_MIN;
        5'd17, 5'd18:  s.fld = FLD_SEC;
        default:       s.sep = CH_COLON;
      endcase
    end else begin
      case (pos) inside
        5'd0, 5'd1:    s.fld = FLD_HOUR;
        5'd3, 5'd4:    s.fld = FLD_MIN;
        5'd6, 5'd7:    s.fld = FLD_SEC;
        default:       s.sep = CH_COLON;
      endcase
    end
    return s;
  endfunction

  // Decimal accumulate of a two-digit field, wrapping to seven bits
  function automatic logic [6:0] acc7(input logic [6:0] acc, input logic [3:0] d);
    logic [10:0] sum;
    sum = 11'(acc) * 11'd10 + 11'(d);
    return sum[6:0];
  endfunction

endpackage

// ----- rtl/timestamp_text_parser_unit.sv -----
// Timestamp text parser: character checks, decimal fields and packed result.
// Throughput: one character beat per cycle, unless a final character meets a full result stage
// that cannot advance; the character stage, result stage and output register each hold one
// beat, so input keeps flowing while a result waits to be taken.
// Reset (rst_n low, synchronous): format_mode returns to full date-time, all field
// accumulators, the position counter and the error and NUL flags clear, pipeline empties.
module timestamp_text_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: format_mode
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  // Character input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tlast,   // last_char
  // Result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [0] valid_res, [27:1] date_value, [45:28] time_value,
                                  // [47:46] zero
);

  // Configuration register
  logic [1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tsp_pkg::MODE_FULL;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // Input register
  logic       a_v_r;
  logic [7:0] a_char_r;
  logic       a_last_r;

  // Result stage and output register
  logic                       b_v_r;
  tsp_pkg::fin_t              b_r;
  logic                       out_v_r;
  logic                       res_ok_r;
  logic [tsp_pkg::DATE_W-1:0] res_date_r;
  logic [tsp_pkg::TIME_W-1:0] res_time_r;

  // Parse state
  logic [4:0]  pos_r,  pos_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  mon_r,  mon_nxt;
  logic [6:0]  day_r,  day_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  min_r,  min_nxt;
  logic [6:0]  sec_r,  sec_nxt;
  logic        err_r,  err_nxt;
  logic        nul_r,  nul_nxt;

  // Handshake chain
  logic c_ready, b_ready, b_adv, a_take;

  assign c_ready   = !out_v_r || out_tready;
  assign b_adv     = b_v_r && c_ready;
  assign b_ready   = !b_v_r || c_ready;
  assign a_take    = a_v_r && (!a_last_r || b_ready);
  assign in_tready = !a_v_r || a_take;

  // Character check and field accumulate for the beat in the input register
  tsp_pkg::slot_t slot;
  logic [3:0]     digit;
  logic           is_digit;
  logic [13:0]    year_step;

  assign slot      = tsp_pkg::slot_of(mode_r, pos_r);
  assign digit     = a_char_r[3:0] - tsp_pkg::CH_ZERO[3:0];
  assign is_digit  = (a_char_r >= tsp_pkg::CH_ZERO) && (a_char_r <= tsp_pkg::CH_NINE);
  assign year_step = 14'(year_r * 14'd10) + 14'(digit);

  always_comb begin
    pos_nxt  = pos_r;
    year_nxt = year_r;
    mon_nxt  = mon_r;
    day_nxt  = day_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    err_nxt  = err_r;
    nul_nxt  = nul_r;
    if (!nul_r) begin
      if (a_char_r == tsp_pkg::CH_NUL) begin
        nul_nxt = 1'b1;
      end else if (pos_r < tsp_pkg::fmt_len(mode_r)) begin
        pos_nxt = pos_r + 5'd1;
        if (slot.fld == tsp_pkg::FLD_SEP) begin
          if (a_char_r != slot.sep) err_nxt = 1'b1;
        end else if (!is_digit) begin
          err_nxt = 1'b1;
        end else begin
          unique case (slot.fld)
            tsp_pkg::FLD_YEAR: year_nxt = year_step;
            tsp_pkg::FLD_MON:  mon_nxt  = tsp_pkg::acc7(mon_r, digit);
            tsp_pkg::FLD_DAY:  day_nxt  = tsp_pkg::acc7(day_r, digit);
            tsp_pkg::FLD_HOUR: hour_nxt = tsp_pkg::acc7(hour_r, digit);
            tsp_pkg::FLD_MIN:  min_nxt  = tsp_pkg::acc7(min_r, digit);
            default:           sec_nxt  = tsp_pkg::acc7(sec_r, digit);
          endcase
        end
      end
    end
  end

  // Input register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_tready) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_char_r <= in_tdata;
      a_last_r <= in_tlast;
    end
  end

  // Parse state update; the final character clears it for the next string
  always_ff @(posedge clk) begin
    if (!rst_n || (a_take && a_last_r)) begin
      pos_r  <= '0;
      year_r <= '0;
      mon_r  <= '0;
      day_r  <= '0;
      hour_r <= '0;
      min_r  <= '0;
      sec_r  <= '0;
      err_r  <= 1'b0;
      nul_r  <= 1'b0;
    end else if (a_take) begin
      pos_r  <= pos_nxt;
      year_r <= year_nxt;
      mon_r  <= mon_nxt;
      day_r  <= day_nxt;
      hour_r <= hour_nxt;
      min_r  <= min_nxt;
      sec_r  <= sec_nxt;
      err_r  <= err_nxt;
      nul_r  <= nul_nxt;
    end
  end

  // Result stage: captures the finished fields of a string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (a_take && a_last_r) begin
      b_v_r <= 1'b1;
    end else if (b_adv) begin
      b_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && a_last_r) begin
      b_r.mode   <= mode_r;
      b_r.pos    <= pos_nxt;
      b_r.err    <= err_nxt;
      b_r.year   <= year_nxt;
      b_r.mon    <= mon_nxt;
      b_r.day    <= day_nxt;
      b_r.hour   <= hour_nxt;
      b_r.minute <= min_nxt;
      b_r.sec    <= sec_nxt;
    end
  end

  // Range checks and decimal packing
  logic        ok;
  logic [27:0] date_w;
  logic [17:0] hms_w;
  logic [17:0] hm_w;

  always_comb begin
    ok = (b_r.mode != 2'd3) && !b_r.err && (b_r.pos == tsp_pkg::fmt_len(b_r.mode))
         && (b_r.hour <= tsp_pkg::MAX_HOUR) && (b_r.minute <= tsp_pkg::MAX_MIN);
    if (b_r.mode != tsp_pkg::MODE_HM && b_r.sec > tsp_pkg::MAX_SEC) ok = 1'b0;
    if (b_r.mode == tsp_pkg::MODE_FULL) begin
      if (b_r.mon == 7'd0 || b_r.mon > tsp_pkg::MAX_MON) ok = 1'b0;
      if (b_r.day == 7'd0 || b_r.day > tsp_pkg::MAX_DAY) ok = 1'b0;
    end
  end

  assign date_w = 28'(b_r.year) * 28'd10000 + 28'(b_r.mon) * 28'd100 + 28'(b_r.day);
  assign hms_w  = 18'(b_r.hour) * 18'd10000 + 18'(b_r.minute) * 18'd100 + 18'(b_r.sec);
  assign hm_w   = 18'(b_r.hour) * 18'd100 + 18'(b_r.minute);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (c_ready) begin
      out_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      res_ok_r   <= ok;
      res_date_r <= (ok && b_r.mode == tsp_pkg::MODE_FULL) ? date_w[tsp_pkg::DATE_W-1:0] : '0;
      res_time_r <= !ok ? '0 : (b_r.mode == tsp_pkg::MODE_HM) ? hm_w : hms_w;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, res_time_r, res_date_r, res_ok_r};

endmodule

// ----- dv/timestamp_text_parser_unit_tb.sv -----
// Self-checking testbench of the timestamp text parser: character stream in, parse results checked.
module timestamp_text_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_CHARS   = 250;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DATE_BITS      = tsp_pkg::DATE_W;
  localparam int TIME_BITS      = tsp_pkg::TIME_W;

  // One parse result: valid flag, packed date and packed time of day.
  typedef struct packed {
    logic                 ok;
    logic [DATE_BITS-1:0] date;
    logic [TIME_BITS-1:0] tod;
  } stamp_t;

  // Tracks the parser state, predicts each string's result and checks the result beats.
  class stamp_tracker;
    logic [1:0]  mode;
    logic [4:0]  pos;
    logic [13:0] year;
    logic [6:0]  mon, day, hour, minute, sec;
    logic        err, nul_hit;
    stamp_t      expected_q[$];
    int          mismatches;
    int          stamps_checked;
    int          valid_seen;

    function new();
      mode = tsp_pkg::MODE_FULL;
      mismatches = 0;
      stamps_checked = 0;
      valid_seen = 0;
      clear_fields();
    endfunction

    function void clear_fields();
      pos = '0;
      year = '0;
      mon = '0;
      day = '0;
      hour = '0;
      minute = '0;
      sec = '0;
      err = 1'b0;
      nul_hit = 1'b0;
    endfunction

    function void set_mode(logic [1:0] m);
      mode = m;
    endfunction

    function int waiting();
      return expected_q.size();
    endfunction

    // Number of characters in the format of a mode; the unused mode takes none.
    function logic [4:0] span(logic [1:0] m);
      case (m)
        tsp_pkg::MODE_FULL: return tsp_pkg::LEN_FULL;
        tsp_pkg::MODE_HMS:  return tsp_pkg::LEN_HMS;
        tsp_pkg::MODE_HM:   return tsp_pkg::LEN_HM;
        default:            return 5'd0;
      endcase
    endfunction

    // Apply one accepted character; on the final one, queue the expected result.
    function void take_char(logic [7:0] c, logic is_last);
      logic [4:0] idx;
      logic [2:0] fld;
      logic [7:0] sep;
      int         d;
      stamp_t     s;
      logic       ok;
      if (!nul_hit) begin
        if (c == tsp_pkg::CH_NUL) begin
          nul_hit = 1'b1;
        end else if (pos < span(mode)) begin
          // The short formats line up with the time part of the long one.
          idx = (mode == tsp_pkg::MODE_FULL) ? pos : pos + 5'd11;
          fld = tsp_pkg::FLD_SEP;
          sep = tsp_pkg::CH_COLON;
          case (idx)
            5'd0, 5'd1, 5'd2, 5'd3: fld = tsp_pkg::FLD_YEAR;
            5'd4, 5'd7:             sep = tsp_pkg::CH_DASH;
            5'd5, 5'd6:             fld = tsp_pkg::FLD_MON;
            5'd8, 5'd9:             fld = tsp_pkg::FLD_DAY;
            5'd10:                  sep = tsp_pkg::CH_SPACE;
            5'd11, 5'd12:           fld = tsp_pkg::FLD_HOUR;
            5'd14, 5'd15:           fld = tsp_pkg::FLD_MIN;
            5'd17, 5'd18:           fld = tsp_pkg::FLD_SEC;
            default:                sep = tsp_pkg::CH_COLON;
          endcase
          pos = pos + 5'd1;
          if (fld == tsp_pkg::FLD_SEP) begin
            if (c != sep) err = 1'b1;
          end else if (c < tsp_pkg::CH_ZERO || c > tsp_pkg::CH_NINE) begin
            err = 1'b1;
          end else begin
            d = int'(c - tsp_pkg::CH_ZERO);
            case (fld)
              tsp_pkg::FLD_YEAR: year = 14'(year * 10 + d);
              tsp_pkg::FLD_MON:  mon = 7'(mon * 10 + d);
              tsp_pkg::FLD_DAY:  day = 7'(day * 10 + d);
              tsp_pkg::FLD_HOUR: hour = 7'(hour * 10 + d);
              tsp_pkg::FLD_MIN:  minute = 7'(minute * 10 + d);
              default:           sec = 7'(sec * 10 + d);
            endcase
          end
        end
      end
      if (is_last) begin
        ok = (mode <= tsp_pkg::MODE_HM) && !err && (pos == span(mode));
        if (hour > tsp_pkg::MAX_HOUR || minute > tsp_pkg::MAX_MIN) ok = 1'b0;
        if (mode != tsp_pkg::MODE_HM && sec > tsp_pkg::MAX_SEC) ok = 1'b0;
        if (mode == tsp_pkg::MODE_FULL && (mon == 0 || mon > tsp_pkg::MAX_MON ||
                                           day == 0 || day > tsp_pkg::MAX_DAY)) begin
          ok = 1'b0;
        end
        s = '0;
        s.ok = ok;
        if (ok) begin
          if (mode == tsp_pkg::MODE_FULL) begin
            s.date = DATE_BITS'(longint'(year) * 10000 + mon * 100 + day);
          end
          if (mode == tsp_pkg::MODE_HM) s.tod = TIME_BITS'(hour * 100 + minute);
          else s.tod = TIME_BITS'(hour * 10000 + minute * 100 + sec);
          valid_seen++;
        end
        expected_q.push_back(s);
        clear_fields();
      end
    endfunction

    function void report(string what, logic [31:0] want_v, logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH in %s: expected %0d, got %0d", what, want_v, got_v);
      end
    endfunction

    // Compare one result beat with the oldest prediction, field by field.
    function void check_stamp(logic [47:0] beat);
      stamp_t want, got;
      got.ok = beat[0];
      got.date = beat[27:1];
      got.tod = beat[45:28];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: result beat %h with no string pending", beat);
        return;
      end
      want = expected_q.pop_front();
      stamps_checked++;
      if (got.ok !== want.ok) report("valid flag", want.ok, got.ok);
      if (got.date !== want.date) report("date value", want.date, got.date);
      if (got.tod !== want.tod) report("time value", want.tod, got.tod);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] char_in
  logic        in_tlast;    // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;   // [0] valid_res, [27:1] date_value, [45:28] time_value, [47:46] zero

  stamp_tracker tracker;
  logic [1:0]   cur_mode = tsp_pkg::MODE_FULL;
  int           burst_left = 0;
  int           chars_sent = 0;
  int           mode_writes = 0;
  int           quiet = 0;
  logic [8:0]   rx_tick = '0;
  int           failures;

  timestamp_text_parser_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: free-flowing windows, light stalls and heavy stalls in turn.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 9'd1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_tick[8:6] < 3'd2) begin
      out_tready <= 1'b1;
    end else if (rx_tick[8:6] == 3'd7) begin
      out_tready <= ($urandom_range(0, 7) == 0);
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Observe register writes, accepted characters and result beats.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tracker.set_mode(cfg_wdata);
      if (in_tvalid && in_tready) tracker.take_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) tracker.check_stamp(out_tdata);
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding.", tracker.waiting());
      $display("timestamp_text_parser_unit regression: fail");
      $finish;
    end
  end

  // Send one character beat; bursts of random length are separated by random gaps.
  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) send_char(s[i], close && (i == s.len() - 1));
  endtask

  // Hold the sender off until every pending result has come out and the pipe is empty.
  task automatic wait_for_stamps();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_mode = m;
    mode_writes++;
  endtask

  // Field value mostly in range, now and then any two-digit number.
  function automatic int pick(int lo, int hi);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(lo, hi);
  endfunction

  function automatic string well_formed(logic [1:0] m);
    case (m)
      tsp_pkg::MODE_FULL: return $sformatf("%04d-%02d-%02d %02d:%02d:%02d",
                                           $urandom_range(0, 9999), pick(1, 12), pick(1, 31),
                                           pick(0, 23), pick(0, 59), pick(0, 60));
      tsp_pkg::MODE_HMS:  return $sformatf("%02d:%02d:%02d", pick(0, 23), pick(0, 59),
                                           pick(0, 60));
      default:            return $sformatf("%02d:%02d", pick(0, 23), pick(0, 59));
    endcase
  endfunction

  // One random string: well formed, damaged in some way, or plain noise.
  task automatic random_string();
    string s;
    int    k;
    int    tail;
    if ($urandom_range(0, 9) < 2) begin
      k = $urandom_range(1, 24);
      for (int i = 0; i < k; i++) send_char(8'($urandom_range(0, 255)), i == k - 1);
      return;
    end
    s = well_formed(cur_mode);
    case ($urandom_range(0, 7))
      0: begin
        // Damage one position with an arbitrary nonzero byte.
        s.putc($urandom_range(0, s.len() - 1), 8'($urandom_range(1, 255)));
        send_text(s, 1'b1);
      end
      1: send_text(s.substr(0, $urandom_range(0, s.len() - 2)), 1'b1);
      2: begin
        // Characters past the end of the format.
        send_text(s, 1'b0);
        tail = $urandom_range(1, 4);
        for (int i = 0; i < tail; i++) send_char(8'($urandom_range(1, 255)), i == tail - 1);
      end
      3: begin
        // A NUL ends the content early, possibly on the final beat itself.
        k = $urandom_range(0, s.len());
        send_text(s.substr(0, k - 1), 1'b0);
        tail = $urandom_range(0, 3);
        send_char(tsp_pkg::CH_NUL, tail == 0);
        for (int i = 0; i < tail; i++) send_char(8'($urandom_range(0, 255)), i == tail - 1);
      end
      default: send_text(s, 1'b1);
    endcase
  endtask

  initial begin
    string head;
    int    next_write;
    tracker = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= tsp_pkg::MODE_FULL;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Long form after reset: field extremes, range failures, separator and digit errors.
    send_text("9999-12-31 23:59:60", 1'b1);
    send_text("0000-01-01 00:00:00", 1'b1);
    send_text("2000-00-15 12:00:00", 1'b1);
    send_text("2000-10-32 12:00:00", 1'b1);
    send_text("2000-10-10T12:00:00", 1'b1);
    send_text("2000-10-10 1x:00:00", 1'b1);
    wait_for_stamps();

    // Hours, minutes and seconds: each range limit exceeded, then a short string.
    write_mode(tsp_pkg::MODE_HMS);
    send_text("24:00:00", 1'b1);
    send_text("23:60:00", 1'b1);
    send_text("23:59:61", 1'b1);
    send_text("12:34", 1'b1);
    wait_for_stamps();

    // Hours and minutes: extra characters, NUL inside, NUL on the final beat, wrong separator.
    write_mode(tsp_pkg::MODE_HM);
    send_text("00:00#zz", 1'b1);
    send_text("12:", 1'b0);
    send_char(tsp_pkg::CH_NUL, 1'b0);
    send_text("99", 1'b1);
    send_text("12:34", 1'b0);
    send_char(tsp_pkg::CH_NUL, 1'b1);
    send_char(tsp_pkg::CH_NUL, 1'b1);
    send_text("12-34", 1'b1);

    // Mode changes in the middle of a string, one making the hour field wrap.
    send_text("1", 1'b0);
    wait_for_stamps();
    write_mode(tsp_pkg::MODE_HMS);
    send_text("2:34:56", 1'b1);
    send_text("99", 1'b0);
    wait_for_stamps();
    write_mode(tsp_pkg::MODE_FULL);
    send_text("99-12-31 99:59:59", 1'b1);
    wait_for_stamps();

    // The unused mode rejects everything.
    write_mode(2'd3);
    send_text("12:34", 1'b1);
    wait_for_stamps();
    write_mode(tsp_pkg::MODE_FULL);

    // Random strings with a format change at idle every so often.
    chars_sent = 0;
    next_write = $urandom_range(40, 90);
    while (chars_sent < RANDOM_CHARS) begin
      if (chars_sent >= next_write) begin
        wait_for_stamps();
        if ($urandom_range(0, 2) == 0) begin
          head = well_formed(cur_mode);
          send_text(head.substr(0, $urandom_range(0, 3)), 1'b0);
          wait_for_stamps();
        end
        case ($urandom_range(0, 9))
          0:       write_mode(2'd3);
          1, 2, 3: write_mode(tsp_pkg::MODE_FULL);
          4, 5, 6: write_mode(tsp_pkg::MODE_HMS);
          default: write_mode(tsp_pkg::MODE_HM);
        endcase
        next_write = chars_sent + $urandom_range(40, 90);
      end
      random_string();
    end
    send_text("00:00", 1'b1);

    // Let everything drain, then report.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    failures = tracker.mismatches + tracker.waiting();
    if (tracker.waiting() != 0) $display("%0d expected results never arrived.", tracker.waiting());
    $display("Checked %0d parse results (%0d predicted valid) over %0d format register writes,",
             tracker.stamps_checked, tracker.valid_seen, mode_writes);
    $display("with clean, damaged, truncated, NUL-cut and noise strings in all four modes.");
    if (failures == 0) begin
      $display("timestamp_text_parser_unit regression: pass");
    end else begin
      $display("timestamp_text_parser_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tsp_pkg.sv
rtl/timestamp_text_parser_unit.sv
dv/timestamp_text_parser_unit_tb.sv
